FILE: rtl/lmi_pkg.sv
// Shared types, constants and helpers for the three-axis linear move interpolator.
// No dependencies; every other file imports this package.
package lmi_pkg;

  localparam int POS_W      = 32;           // position register width
  localparam int DELTA_W    = POS_W + 1;    // signed delta, span and step counters
  localparam int TGT_W      = 24;           // target coordinate, 1/256 mm
  localparam int SPM_W      = 12;           // steps_per_mm register
  localparam int PT_W       = 32;           // result coordinate width
  localparam int NUM_AXES   = 3;
  localparam int SCALE_SHIFT = 8;           // 1/256 mm to mm
  localparam int PROD_W     = TGT_W + SPM_W + 1;
  localparam int SAT_W      = ((PROD_W > POS_W) ? PROD_W : POS_W) + 1;

  localparam logic [SPM_W-1:0] SPM_RESET = SPM_W'(200);

  localparam logic signed [SAT_W-1:0] POS_MAX = SAT_W'({1'b0, {(POS_W-1){1'b1}}});
  localparam logic signed [SAT_W-1:0] POS_MIN = ~POS_MAX;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

  localparam int OB_DEPTH = 2;
  localparam int OB_AW    = $clog2(OB_DEPTH);
  localparam int OB_CW    = $clog2(OB_DEPTH + 1);

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } lmi_action_e;

  typedef enum logic {
    BK_RUN,
    BK_SPAN
  } lmi_back_state_e;

  typedef struct packed {
    logic                    action;
    logic signed [TGT_W-1:0] target_x;
    logic signed [TGT_W-1:0] target_y;
    logic signed [TGT_W-1:0] target_z;
  } lmi_in_t;

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
    logic                   last_point;
  } lmi_out_t;

  // Command passed from the front end to the move unit: targets already in steps.
  typedef struct packed {
    logic                    action;
    logic signed [POS_W-1:0] tgt_x;
    logic signed [POS_W-1:0] tgt_y;
    logic signed [POS_W-1:0] tgt_z;
  } lmi_cmd_t;

  // product / 256 rounded toward zero, then clamped to the position range
  function automatic logic signed [POS_W-1:0] scale_target(
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0] quo;
    logic signed [SAT_W-1:0]  wide;
    quo = prod >>> SCALE_SHIFT;
    if (prod[PROD_W-1] && (prod[SCALE_SHIFT-1:0] != '0)) begin
      quo = quo + PROD_W'(1);
    end
    wide = SAT_W'(quo);
    if (wide > POS_MAX) begin
      wide = POS_MAX;
    end else if (wide < POS_MIN) begin
      wide = POS_MIN;
    end
    return POS_W'(wide);
  endfunction

endpackage

FILE: rtl/linear_move_interpolator_3axis.sv
// Top level of the three-axis linear move interpolator: configuration register,
// front end, command queue and move unit. Depends on lmi_pkg and the lmi_* modules.
//
// A load transaction (action 0) scales each target from 1/256 mm to motor steps
// (rounded toward zero, clamped) and starts a straight move from the current position;
// each step transaction (action 1) then yields the next point 0..N of that move, N being
// the largest axis distance, with the last point flagged and kept as the new position.
// A load during a move, a step with no move and a load that moves nothing give no result.
// Step transactions are taken one per clock while full is low and, once the pipe is
// full, a point leaves every clock while pop is held and nothing stalls; a load
// occupies the move unit for a delta phase, then a span phase. A step's point passes the
// input register, multiplier register, command queue and result buffer in that order
// before it is offered. The queue (four commands) and the two-entry result buffer let
// input and output stall independently. steps_per_mm may only be written while idle.
module linear_move_interpolator_3axis import lmi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [SPM_W-1:0] cfg_data_i,
  input  logic             push,
  output logic             full,
  input  lmi_in_t          item_i,
  input  logic             pop,
  output logic             empty,
  output lmi_out_t         point_o
);

  logic [SPM_W-1:0] steps_per_mm_q;
  logic             fe_valid;
  lmi_cmd_t         fe_cmd;
  logic             cq_full;
  logic             cq_empty;
  lmi_cmd_t         cq_data;
  logic             cq_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_per_mm_q <= SPM_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      steps_per_mm_q <= cfg_data_i;
    end
  end

  lmi_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .steps_per_mm_i (steps_per_mm_q),
    .push_i         (push),
    .full_o         (full),
    .item_i         (item_i),
    .cmd_valid_o    (fe_valid),
    .cmd_o          (fe_cmd),
    .cmd_ready_i    (!cq_full)
  );

  lmi_cmd_queue u_cmd_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fe_valid),
    .wr_data_i (fe_cmd),
    .full_o    (cq_full),
    .rd_en_i   (cq_pop),
    .rd_data_o (cq_data),
    .empty_o   (cq_empty)
  );

  lmi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cq_empty),
    .cmd_i       (cq_data),
    .cmd_pop_o   (cq_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .point_o     (point_o)
  );

endmodule

FILE: rtl/lmi_front.sv
// Front end: input register and target scaling pipeline (multiply, then /256 and clamp).
// Depends on lmi_pkg.
module lmi_front import lmi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SPM_W-1:0] steps_per_mm_i,
  input  logic             push_i,
  output logic             full_o,
  input  lmi_in_t          item_i,
  output logic             cmd_valid_o,
  output lmi_cmd_t         cmd_o,
  input  logic             cmd_ready_i
);

  logic                     a_valid_q;
  lmi_in_t                  a_item_q;
  logic                     b_valid_q;
  logic                     b_action_q;
  logic signed [PROD_W-1:0] b_prod_q [NUM_AXES];
  logic signed [PROD_W-1:0] b_prod_d [NUM_AXES];
  logic signed [SPM_W:0]    spm_s;
  logic                     a_ready;
  logic                     b_ready;

  assign b_ready = !b_valid_q || cmd_ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign full_o  = !a_ready;

  assign spm_s       = signed'({1'b0, steps_per_mm_i});
  assign b_prod_d[0] = a_item_q.target_x * spm_s;
  assign b_prod_d[1] = a_item_q.target_y * spm_s;
  assign b_prod_d[2] = a_item_q.target_z * spm_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= push_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && a_ready) begin
      a_item_q <= item_i;
    end
    if (a_valid_q && b_ready) begin
      b_action_q  <= a_item_q.action;
      b_prod_q[0] <= b_prod_d[0];
      b_prod_q[1] <= b_prod_d[1];
      b_prod_q[2] <= b_prod_d[2];
    end
  end

  assign cmd_valid_o  = b_valid_q;
  assign cmd_o.action = b_action_q;
  assign cmd_o.tgt_x  = scale_target(b_prod_q[0]);
  assign cmd_o.tgt_y  = scale_target(b_prod_q[1]);
  assign cmd_o.tgt_z  = scale_target(b_prod_q[2]);

endmodule

FILE: rtl/lmi_cmd_queue.sv
// Short command queue decoupling the scaling front end from the move unit.
// Depends on lmi_pkg.
module lmi_cmd_queue import lmi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_en_i,
  input  lmi_cmd_t wr_data_i,
  output logic     full_o,
  input  logic     rd_en_i,
  output lmi_cmd_t rd_data_o,
  output logic     empty_o
);

  lmi_cmd_t         entries_q [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_q;
  logic [CQ_AW-1:0] rd_ptr_q;
  logic [CQ_CW-1:0] count_q;
  logic             do_wr;
  logic             do_rd;

  assign full_o    = (count_q == CQ_CW'(CQ_DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + CQ_AW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + CQ_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CQ_CW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CQ_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/lmi_back.sv
// Move unit: sets up a move from a load command and runs the DDA accumulators per step,
// with a two-entry result buffer. Depends on lmi_pkg.
module lmi_back import lmi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  lmi_cmd_t cmd_i,
  output logic     cmd_pop_o,
  input  logic     pop_i,
  output logic     empty_o,
  output lmi_out_t point_o
);

  lmi_back_state_e st_q, st_d;
  logic do_load;
  logic do_span;
  logic do_step;

  logic                      move_active_q;
  logic [DELTA_W-1:0]        span_q;
  logic [DELTA_W-1:0]        idx_q;
  logic                      last_s;
  logic [DELTA_W-1:0]        mag [NUM_AXES];
  logic signed [POS_W-1:0]   tgt [NUM_AXES];
  logic signed [POS_W-1:0]   pt  [NUM_AXES];
  logic [DELTA_W-1:0]        mag01;
  logic [DELTA_W-1:0]        mag_max;

  lmi_out_t         ob_q [OB_DEPTH];
  logic [OB_AW-1:0] ob_wr_q;
  logic [OB_AW-1:0] ob_rd_q;
  logic [OB_CW-1:0] ob_cnt_q;
  logic             ob_space;
  logic             ob_pop;

  assign tgt[0] = cmd_i.tgt_x;
  assign tgt[1] = cmd_i.tgt_y;
  assign tgt[2] = cmd_i.tgt_z;

  assign ob_space = (ob_cnt_q != OB_CW'(OB_DEPTH));
  assign empty_o  = (ob_cnt_q == '0);
  assign ob_pop   = pop_i && !empty_o;
  assign point_o  = ob_q[ob_rd_q];

  assign last_s = (idx_q == span_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_RUN;
    end else begin
      st_q <= st_d;
    end
  end

  // Loads while a move runs and steps while idle are consumed and dropped.
  always_comb begin
    st_d      = st_q;
    cmd_pop_o = 1'b0;
    do_load   = 1'b0;
    do_span   = 1'b0;
    do_step   = 1'b0;
    unique case (st_q)
      BK_RUN: begin
        if (cmd_valid_i) begin
          if (cmd_i.action == ACT_STEP) begin
            if (!move_active_q) begin
              cmd_pop_o = 1'b1;
            end else if (ob_space) begin
              cmd_pop_o = 1'b1;
              do_step   = 1'b1;
            end
          end else begin
            cmd_pop_o = 1'b1;
            if (!move_active_q) begin
              do_load = 1'b1;
              st_d    = BK_SPAN;
            end
          end
        end
      end
      BK_SPAN: begin
        do_span = 1'b1;
        st_d    = BK_RUN;
      end
      default: st_d = BK_RUN;
    endcase
  end

  // Per axis: quotient/remainder of |delta|*i/N kept incrementally (remainder < N).
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [POS_W-1:0]   pos_q;
    logic                      neg_q;
    logic [DELTA_W-1:0]        mag_q;
    logic [DELTA_W-1:0]        acc_q;
    logic [DELTA_W-1:0]        rem_q;
    logic signed [DELTA_W-1:0] delta_s;
    logic [DELTA_W-1:0]        mag_s;
    logic signed [DELTA_W-1:0] start_s;
    logic signed [DELTA_W-1:0] sum_s;
    logic signed [DELTA_W-1:0] pt_s;
    logic [DELTA_W:0]          rsum_s;
    logic [DELTA_W-1:0]        acc_d;
    logic [DELTA_W-1:0]        rem_d;

    assign delta_s = DELTA_W'(tgt[a]) - DELTA_W'(pos_q);
    assign mag_s   = delta_s[DELTA_W-1] ? DELTA_W'(-delta_s) : DELTA_W'(delta_s);
    assign start_s = DELTA_W'(pos_q);
    assign sum_s   = neg_q ? start_s - signed'(acc_q) : start_s + signed'(acc_q);

    // whole-sum truncation toward zero when a fraction is left over
    always_comb begin
      pt_s = sum_s;
      if (rem_q != '0) begin
        if (!neg_q && (sum_s < 0)) begin
          pt_s = sum_s + DELTA_W'(1);
        end else if (neg_q && (sum_s > 0)) begin
          pt_s = sum_s - DELTA_W'(1);
        end
      end
    end

    assign rsum_s = {1'b0, rem_q} + {1'b0, mag_q};

    always_comb begin
      if (rsum_s >= {1'b0, span_q}) begin
        rem_d = DELTA_W'(rsum_s - {1'b0, span_q});
        acc_d = acc_q + DELTA_W'(1);
      end else begin
        rem_d = DELTA_W'(rsum_s);
        acc_d = acc_q;
      end
    end

    assign pt[a]  = POS_W'(pt_s);
    assign mag[a] = mag_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q <= '0;
      end else if (do_step && last_s) begin
        pos_q <= pt[a];
      end
    end

    always_ff @(posedge clk_i) begin
      if (do_load) begin
        neg_q <= delta_s[DELTA_W-1];
        mag_q <= mag_s;
      end
      if (do_span) begin
        acc_q <= '0;
        rem_q <= '0;
      end else if (do_step) begin
        acc_q <= acc_d;
        rem_q <= rem_d;
      end
    end
  end

  assign mag01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign mag_max = (mag01 > mag[2]) ? mag01 : mag[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_active_q <= 1'b0;
      idx_q         <= '0;
    end else if (do_span) begin
      move_active_q <= (mag_max != '0);
      idx_q         <= '0;
    end else if (do_step) begin
      if (last_s) begin
        move_active_q <= 1'b0;
        idx_q         <= '0;
      end else begin
        idx_q <= idx_q + DELTA_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_span) begin
      span_q <= mag_max;
    end
    if (do_step) begin
      ob_q[ob_wr_q] <= '{point_x:    PT_W'(pt[0]),
                         point_y:    PT_W'(pt[1]),
                         point_z:    PT_W'(pt[2]),
                         last_point: last_s};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= '0;
      ob_rd_q  <= '0;
      ob_cnt_q <= '0;
    end else begin
      if (do_step) begin
        ob_wr_q <= (ob_wr_q == OB_AW'(OB_DEPTH - 1)) ? '0 : ob_wr_q + OB_AW'(1);
      end
      if (ob_pop) begin
        ob_rd_q <= (ob_rd_q == OB_AW'(OB_DEPTH - 1)) ? '0 : ob_rd_q + OB_AW'(1);
      end
      if (do_step && !ob_pop) begin
        ob_cnt_q <= ob_cnt_q + OB_CW'(1);
      end else if (ob_pop && !do_step) begin
        ob_cnt_q <= ob_cnt_q - OB_CW'(1);
      end
    end
  end

endmodule

FILE: rtl/lmi_checker.sv
// Port-level checks for linear_move_interpolator_3axis, attached by bind.
// Depends on lmi_pkg.
module lmi_checker import lmi_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     push,
  input logic     full,
  input logic     pop,
  input logic     empty,
  input lmi_out_t point_o
);

  logic                  seen_push_q;
  logic signed [PT_W-1:0] prev_x_q;
  logic signed [PT_W-1:0] prev_y_q;
  logic signed [PT_W-1:0] prev_z_q;
  logic                  prev_last_q;
  logic                  out_take;
  logic signed [PT_W:0]  dx;
  logic signed [PT_W:0]  dy;
  logic signed [PT_W:0]  dz;

  assign out_take = pop && !empty;
  assign dx = {point_o.point_x[PT_W-1], point_o.point_x} - {prev_x_q[PT_W-1], prev_x_q};
  assign dy = {point_o.point_y[PT_W-1], point_o.point_y} - {prev_y_q[PT_W-1], prev_y_q};
  assign dz = {point_o.point_z[PT_W-1], point_o.point_z} - {prev_z_q[PT_W-1], prev_z_q};

  // position starts at the origin, so the first point follows a notional last point at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_push_q <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
      prev_last_q <= 1'b1;
    end else begin
      if (push && !full) begin
        seen_push_q <= 1'b1;
      end
      if (out_take) begin
        prev_x_q    <= point_o.point_x;
        prev_y_q    <= point_o.point_y;
        prev_z_q    <= point_o.point_z;
        prev_last_q <= point_o.last_point;
      end
    end
  end

  a_no_result_before_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !seen_push_q |-> empty
  ) else $error("result offered before any input transaction");

  a_result_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(point_o))
  ) else $error("waiting result changed or vanished");

  a_move_starts_at_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_take && prev_last_q) |->
      (point_o.point_x == prev_x_q && point_o.point_y == prev_y_q &&
       point_o.point_z == prev_z_q)
  ) else $error("move does not start at the previous end point");

  a_unit_stride: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_take |->
      ((dx == '0 || dx == (PT_W+1)'(1) || dx == -(PT_W+1)'(1)) &&
       (dy == '0 || dy == (PT_W+1)'(1) || dy == -(PT_W+1)'(1)) &&
       (dz == '0 || dz == (PT_W+1)'(1) || dz == -(PT_W+1)'(1)))
  ) else $error("consecutive points more than one step apart");

endmodule

bind linear_move_interpolator_3axis lmi_checker u_lmi_checker (.*);
